[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

[src/mcw_pkg.sv]
package mcw_pkg;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int CNT_W   = 32;
    localparam int MV_W    = 16;
    localparam int LIM_W   = 15;
    localparam int AGE_W   = 8;
    localparam int ANGLE_W = 12;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // encoder counts per revolution, power of two
    localparam int COUNTS_PER_REV = 2048;
    localparam int CPR_BITS       = $clog2(COUNTS_PER_REV);
    localparam int HALF_REV       = COUNTS_PER_REV / 2;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        COLOUR_RED   = 2'd0,
        COLOUR_BLUE  = 2'd1,
        COLOUR_GREEN = 2'd2
    } t_colour;

    typedef enum logic [1:0] {
        REG_ARM_OFFSET  = 2'd0,
        REG_PEND_OFFSET = 2'd1,
        REG_TIMEOUT     = 2'd2,
        REG_VOLT_LIMIT  = 2'd3
    } t_reg_idx;

    localparam logic [DATA_W-1:0] TIMEOUT_RST = 32'd10;
    localparam logic [DATA_W-1:0] LIMIT_RST   = 32'd10000;

    typedef struct packed {
        logic signed [CNT_W-1:0] arm_offset;
        logic signed [CNT_W-1:0] pendulum_offset;
        logic [AGE_W-1:0]        timeout_ticks;
        logic [LIM_W-1:0]        voltage_limit_mv;
    } t_cfg;

    typedef struct packed {
        logic                    operation;
        logic signed [CNT_W-1:0] arm_count;
        logic signed [CNT_W-1:0] pendulum_count;
        logic [SEQ_W-1:0]        command_seq;
        logic signed [MV_W-1:0]  command_mv;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0]          sample_seq;
        logic signed [CNT_W-1:0]   arm_angle;
        logic signed [ANGLE_W-1:0] pendulum_angle;
        logic signed [MV_W-1:0]    motor_mv;
        t_colour                   status_colour;
        logic                      colour_changed;
    } t_out_item;

endpackage

[src/mcw_in_if.sv]
interface mcw_in_if;
    import mcw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [CNT_W-1:0] arm_count;
    logic signed [CNT_W-1:0] pendulum_count;
    logic [SEQ_W-1:0]        command_seq;
    logic signed [MV_W-1:0]  command_mv;

    modport source (
        output valid, operation, arm_count, pendulum_count, command_seq, command_mv,
        input  ready
    );

    modport sink (
        input  valid, operation, arm_count, pendulum_count, command_seq, command_mv,
        output ready
    );
endinterface

[src/mcw_out_if.sv]
interface mcw_out_if;
    import mcw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SEQ_W-1:0]          sample_seq;
    logic signed [CNT_W-1:0]   arm_angle;
    logic signed [ANGLE_W-1:0] pendulum_angle;
    logic signed [MV_W-1:0]    motor_mv;
    logic [1:0]                status_colour;
    logic                      colour_changed;

    modport source (
        output valid, sample_seq, arm_angle, pendulum_angle, motor_mv,
               status_colour, colour_changed,
        input  ready
    );

    modport sink (
        input  valid, sample_seq, arm_angle, pendulum_angle, motor_mv,
               status_colour, colour_changed,
        output ready
    );
endinterface

[src/motor_command_watchdog.sv]
// Motor command watchdog. Command words (operation 0) are checked against the
// last accepted sequence number and their voltage clamped to +/- the limit;
// they give no output word. Each tick word (operation 1) gives one output
// word with the tick number, arm angle, pendulum angle wrapped to half a
// revolution, the applied voltage (zero until a command arrives or once its
// age in ticks passes the timeout) and the status colour with a change flag.
// One word is taken every cycle unless the input stalls; a tick passes the
// input register, then the result register, before its result is valid on
// the output. The input stalls only while a tick waits in the input register
// behind an output word that has not been taken. Registers must be written
// over APB only while no word is in flight; the block does not enforce this.
module motor_command_watchdog (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mcw_in_if.sink                     i_in,
    mcw_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mcw_pkg::ADDR_W-1:0] paddr,
    input  logic [mcw_pkg::DATA_W-1:0] pwdata,
    output logic [mcw_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mcw_pkg::*;
    `include "assert_macros.svh"

    t_cfg cfg;

    mcw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input stage
    logic     r_s1_valid;
    t_in_item r_s1;
    logic     s1_adv;
    logic     cmd_adv;
    logic     tick_adv;

    // result stage
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // watchdog state
    logic [SEQ_W-1:0]       r_tick;
    logic [SEQ_W-1:0]       r_last_seq;
    logic signed [MV_W-1:0] r_held;
    logic                   r_ever;
    logic                   r_pending;
    logic [AGE_W-1:0]       r_age;
    t_colour                r_colour;

    logic                        seq_ok;
    logic signed [MV_W-1:0]      lim;
    logic signed [MV_W-1:0]      n_held;
    logic [AGE_W-1:0]            n_age;
    t_colour                     n_colour;
    logic [CNT_W-1:0]            pend_diff;
    logic [CPR_BITS-1:0]         pend_low;
    logic signed [CPR_BITS:0]    pend_wrap;

    assign s1_adv   = r_s1_valid &&
                      (r_s1.operation == OP_COMMAND || !r_out_valid || o_out.ready);
    assign cmd_adv  = s1_adv && r_s1.operation == OP_COMMAND;
    assign tick_adv = s1_adv && r_s1.operation == OP_TICK;

    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.operation      <= i_in.operation;
            r_s1.arm_count      <= i_in.arm_count;
            r_s1.pendulum_count <= i_in.pendulum_count;
            r_s1.command_seq    <= i_in.command_seq;
            r_s1.command_mv     <= i_in.command_mv;
        end
    end

    // command path
    always_comb begin
        seq_ok = !r_ever || (r_s1.command_seq > r_last_seq);
        lim    = signed'({1'b0, cfg.voltage_limit_mv});
        if (r_s1.command_mv > lim) begin
            n_held = lim;
        end else if (r_s1.command_mv < -lim) begin
            n_held = -lim;
        end else begin
            n_held = r_s1.command_mv;
        end
    end

    // tick path
    always_comb begin
        if (r_pending) begin
            n_age = '0;
        end else if (r_ever && r_age != AGE_MAX) begin
            n_age = r_age + 1'b1;
        end else begin
            n_age = r_age;
        end

        if (!r_ever) begin
            n_colour = COLOUR_BLUE;
        end else if (n_age > cfg.timeout_ticks || n_age == AGE_MAX) begin
            n_colour = COLOUR_RED;
        end else begin
            n_colour = COLOUR_GREEN;
        end

        // modulo a power-of-two revolution, then fold the upper half negative
        pend_diff = r_s1.pendulum_count - cfg.pendulum_offset;
        pend_low  = pend_diff[CPR_BITS-1:0];
        if (pend_low > CPR_BITS'(HALF_REV)) begin
            pend_wrap = signed'({1'b1, pend_low});
        end else begin
            pend_wrap = signed'({1'b0, pend_low});
        end

        n_out.sample_seq     = r_tick;
        n_out.arm_angle      = r_s1.arm_count - cfg.arm_offset;
        n_out.pendulum_angle = ANGLE_W'(pend_wrap);
        n_out.motor_mv       = (n_colour == COLOUR_GREEN) ? r_held : '0;
        n_out.status_colour  = n_colour;
        n_out.colour_changed = (n_colour != r_colour);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_last_seq <= '0;
            r_held     <= '0;
            r_ever     <= 1'b0;
            r_pending  <= 1'b0;
            r_age      <= '0;
            r_colour   <= COLOUR_BLUE;
        end else if (cmd_adv && seq_ok) begin
            r_last_seq <= r_s1.command_seq;
            r_held     <= n_held;
            r_ever     <= 1'b1;
            r_pending  <= 1'b1;
        end else if (tick_adv) begin
            r_tick    <= r_tick + 1'b1;
            r_pending <= 1'b0;
            r_age     <= n_age;
            r_colour  <= n_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample_seq     = r_out.sample_seq;
    assign o_out.arm_angle      = r_out.arm_angle;
    assign o_out.pendulum_angle = r_out.pendulum_angle;
    assign o_out.motor_mv       = r_out.motor_mv;
    assign o_out.status_colour  = r_out.status_colour;
    assign o_out.colour_changed = r_out.colour_changed;

    `ASSERT_ALWAYS(a_pending_has_cmd,
        r_pending |-> r_ever,
        "pending command without any command")
    `ASSERT_CLK(a_s1_held,
        (r_s1_valid && !s1_adv) |=> r_s1_valid,
        "stalled word dropped")
    `ASSERT_CLK(a_motor_off,
        (r_out_valid && r_out.status_colour != COLOUR_GREEN) |-> (r_out.motor_mv == '0),
        "voltage applied while not running")
    `ASSERT_CLK(a_seq_out,
        tick_adv |=> (r_out.sample_seq == $past(r_tick)),
        "tick number mismatch")
    `ASSERT_CLK(a_age_step,
        (tick_adv && !r_pending && r_ever && r_age != AGE_MAX)
            |=> (r_age == $past(r_age) + 8'd1),
        "command age did not advance")
endmodule

[src/mcw_regs.sv]
module mcw_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcw_pkg::ADDR_W-1:0]   paddr,
    input  logic [mcw_pkg::DATA_W-1:0]   pwdata,
    output logic [mcw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output mcw_pkg::t_cfg                o_cfg
);
    import mcw_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_offset       <= '0;
            r_cfg.pendulum_offset  <= '0;
            r_cfg.timeout_ticks    <= TIMEOUT_RST[AGE_W-1:0];
            r_cfg.voltage_limit_mv <= LIMIT_RST[LIM_W-1:0];
        end else if (wr_en) begin
            case (idx)
                REG_ARM_OFFSET:  r_cfg.arm_offset       <= pwdata;
                REG_PEND_OFFSET: r_cfg.pendulum_offset  <= pwdata;
                REG_TIMEOUT:     r_cfg.timeout_ticks    <= pwdata[AGE_W-1:0];
                REG_VOLT_LIMIT:  r_cfg.voltage_limit_mv <= pwdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ARM_OFFSET:  prdata = r_cfg.arm_offset;
            REG_PEND_OFFSET: prdata = r_cfg.pendulum_offset;
            REG_TIMEOUT:     prdata = {{(DATA_W-AGE_W){1'b0}}, r_cfg.timeout_ticks};
            REG_VOLT_LIMIT:  prdata = {{(DATA_W-LIM_W){1'b0}}, r_cfg.voltage_limit_mv};
            default:         prdata = '0;
        endcase
    end
endmodule
